>>> hdl/tfs_pkg.sv
// Shared types and constants for the telemetry frame serializer.
package tfs_pkg;

    localparam int WORD_W    = 16;
    localparam int VALUE_W   = 24;
    localparam int PROD_W    = 31;
    localparam int NUM_WORDS = 9;
    localparam int POS_W     = 5;

    localparam logic [1:0] OP_PID   = 2'd0;
    localparam logic [1:0] OP_EULER = 2'd1;
    localparam logic [1:0] OP_RAW   = 2'd2;

    localparam logic [7:0] HDR_BYTE       = 8'hAA;
    localparam logic [7:0] TARGET_RESET   = 8'hFF;
    localparam logic [7:0] CODE_PID       = 8'h0A;
    localparam logic [7:0] CODE_EULER     = 8'h03;
    localparam logic [7:0] CODE_RAW_IMU   = 8'h01;
    localparam logic [7:0] CODE_RAW_MAG   = 8'h02;
    localparam logic [7:0] LEN_PID        = 8'd6;
    localparam logic [7:0] LEN_EULER      = 8'd7;
    localparam logic [7:0] LEN_RAW_IMU    = 8'd13;
    localparam logic [7:0] LEN_RAW_MAG    = 8'd14;
    localparam logic [7:0] STATUS_OK      = 8'h01;

    localparam logic signed [7:0] CENTI_SCALE = 8'sd100;

    localparam logic [POS_W-1:0] BODY_PID     = 5'd10;
    localparam logic [POS_W-1:0] BODY_EULER   = 5'd11;
    localparam logic [POS_W-1:0] BODY_RAW_IMU = 5'd17;
    localparam logic [POS_W-1:0] BODY_RAW_MAG = 5'd18;
    localparam logic [POS_W-1:0] HDR_LEN      = 5'd4;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value0;
        logic signed [VALUE_W-1:0] value1;
        logic signed [VALUE_W-1:0] value2;
        logic signed [WORD_W-1:0]  gyro_x;
        logic signed [WORD_W-1:0]  gyro_y;
        logic signed [WORD_W-1:0]  gyro_z;
        logic signed [WORD_W-1:0]  mag_x;
        logic signed [WORD_W-1:0]  mag_y;
        logic signed [WORD_W-1:0]  mag_z;
    } req_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       run_last;
    } frm_t;

    typedef struct packed {
        logic [1:0]                       op;
        logic [2:0][PROD_W-1:0]           prod;
        logic [NUM_WORDS-1:0][WORD_W-1:0] word;
    } scl_t;

endpackage

>>> hdl/tfs_scale.sv
// Input stage: registers the request and the Q.8 times 100 products.
module tfs_scale (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tfs_pkg::req_t req,
    output logic          scl_valid,
    input  logic          scl_ready,
    output tfs_pkg::scl_t scl
);
    import tfs_pkg::*;

    logic vld_reg;
    scl_t scl_reg;
    scl_t scl_next;

    assign req_ready = !vld_reg || scl_ready;
    assign scl_valid = vld_reg;
    assign scl       = scl_reg;

    always_comb
    begin
        scl_next.op      = req.op;
        scl_next.prod[0] = PROD_W'(PROD_W'(req.value0) * PROD_W'(CENTI_SCALE));
        scl_next.prod[1] = PROD_W'(PROD_W'(req.value1) * PROD_W'(CENTI_SCALE));
        scl_next.prod[2] = PROD_W'(PROD_W'(req.value2) * PROD_W'(CENTI_SCALE));
        scl_next.word[0] = req.value0[WORD_W-1:0];
        scl_next.word[1] = req.value1[WORD_W-1:0];
        scl_next.word[2] = req.value2[WORD_W-1:0];
        scl_next.word[3] = req.gyro_x;
        scl_next.word[4] = req.gyro_y;
        scl_next.word[5] = req.gyro_z;
        scl_next.word[6] = req.mag_x;
        scl_next.word[7] = req.mag_y;
        scl_next.word[8] = req.mag_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            scl_reg <= scl_next;
        end
    end

endmodule

>>> hdl/tfs_serializer.sv
// Frame builder: walks one request's frames, a byte per cycle unless stalled, with running checksums.
module tfs_serializer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          scl_valid,
    output logic          scl_ready,
    input  tfs_pkg::scl_t scl,
    input  logic [7:0]    target_address,
    output logic          frm_valid,
    input  logic          frm_ready,
    output tfs_pkg::frm_t frm
);
    import tfs_pkg::*;

    logic                             busy_reg;
    logic                             second_reg;
    logic [1:0]                       op_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0] word_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0] word_next;
    logic [POS_W-1:0]                 pos_reg;
    logic [7:0]                       sum_reg;
    logic [7:0]                       chk_reg;
    logic                             out_vld_reg;
    frm_t                             frm_reg;

    logic             out_take;
    logic             emit;
    logic             load;
    logic [POS_W-1:0] body_len;
    logic [7:0]       code_byte;
    logic [7:0]       len_byte;
    logic [3:0]       num_words;
    logic [3:0]       word_base;
    logic [3:0]       word_off;
    logic [3:0]       word_idx;
    logic [WORD_W-1:0] cur_word;
    logic [POS_W-1:0] body_pos;
    logic [7:0]       cur_byte;
    logic             at_sum;
    logic             at_chk;
    logic             run_end;
    logic [PROD_W-1:0] biased [3];

    assign out_take  = !out_vld_reg || frm_ready;
    assign emit      = busy_reg && out_take;
    assign scl_ready = !busy_reg || (emit && run_end);
    assign load      = scl_valid && scl_ready;
    assign frm_valid = out_vld_reg;
    assign frm       = frm_reg;

    always_comb
    begin
        case (op_reg)
            OP_PID:
            begin
                body_len  = BODY_PID;
                code_byte = CODE_PID;
                len_byte  = LEN_PID;
                num_words = 4'd3;
            end
            OP_EULER:
            begin
                body_len  = BODY_EULER;
                code_byte = CODE_EULER;
                len_byte  = LEN_EULER;
                num_words = 4'd3;
            end
            default:
            begin
                body_len  = second_reg ? BODY_RAW_MAG : BODY_RAW_IMU;
                code_byte = second_reg ? CODE_RAW_MAG : CODE_RAW_IMU;
                len_byte  = second_reg ? LEN_RAW_MAG : LEN_RAW_IMU;
                num_words = second_reg ? 4'd3 : 4'd6;
            end
        endcase
    end

    always_comb
    begin
        body_pos  = pos_reg - HDR_LEN;
        word_off  = 4'(body_pos >> 1);
        word_base = second_reg ? 4'd6 : 4'd0;
        word_idx  = word_base + word_off;
        cur_word  = '0;
        at_sum    = (pos_reg == body_len);
        at_chk    = (pos_reg == body_len + POS_W'(1));
        run_end   = at_chk && ((op_reg != OP_RAW) || second_reg);
        cur_byte  = 8'h00;
        if (pos_reg < HDR_LEN)
        begin
            case (pos_reg[1:0])
                2'd0:    cur_byte = HDR_BYTE;
                2'd1:    cur_byte = target_address;
                2'd2:    cur_byte = code_byte;
                default: cur_byte = len_byte;
            endcase
        end
        else if (pos_reg < body_len)
        begin
            if (word_off < num_words)
            begin
                cur_word = word_reg[word_idx];
                cur_byte = pos_reg[0] ? cur_word[15:8] : cur_word[7:0];
            end
            else if ((op_reg != OP_PID) && (pos_reg == body_len - POS_W'(1)))
            begin
                cur_byte = STATUS_OK;
            end
        end
        else if (at_sum)
        begin
            cur_byte = sum_reg;
        end
        else
        begin
            cur_byte = chk_reg;
        end
    end

    // Q.8 hundredths: bias negatives so the shift truncates toward zero
    always_comb
    begin
        word_next = scl.word;
        for (int i = 0; i < 3; i++)
        begin
            biased[i] = scl.prod[i] + (scl.prod[i][PROD_W-1] ? PROD_W'(255) : '0);
            if (scl.op != OP_RAW)
            begin
                word_next[i] = biased[i][8 +: WORD_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            second_reg  <= 1'b0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            chk_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                out_vld_reg <= busy_reg;
            end
            if (load)
            begin
                busy_reg   <= (scl.op == OP_PID) || (scl.op == OP_EULER) || (scl.op == OP_RAW);
                second_reg <= 1'b0;
                pos_reg    <= '0;
                sum_reg    <= '0;
                chk_reg    <= '0;
            end
            else if (emit)
            begin
                if (at_chk)
                begin
                    sum_reg    <= '0;
                    chk_reg    <= '0;
                    pos_reg    <= '0;
                    second_reg <= 1'b1;
                    if (run_end)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                else if (at_sum)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                else
                begin
                    sum_reg <= sum_reg + cur_byte;
                    chk_reg <= chk_reg + sum_reg + cur_byte;
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= scl.op;
            word_reg <= word_next;
        end
        if (emit)
        begin
            frm_reg.data_byte <= cur_byte;
            frm_reg.frame_end <= at_chk;
            frm_reg.run_last  <= run_end;
        end
    end

endmodule

>>> hdl/telemetry_frame_serializer.sv
// Path: a request is registered in the scale stage, loaded into the serializer, then sent from the output register.
// Throughput: one byte per cycle from the output register unless frm_ready stalls;
// the next request's first byte follows the previous last byte with no gap
// when that request is already waiting in the scale stage.
// Reset: clears all valid and sequencing state; target_address returns to 0xFF.
// Top level of the telemetry frame serializer.
module telemetry_frame_serializer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_data,
    input  logic          req_valid,
    output logic          req_ready,
    input  tfs_pkg::req_t req,
    output logic          frm_valid,
    input  logic          frm_ready,
    output tfs_pkg::frm_t frm
);
    import tfs_pkg::*;

    logic [7:0] target_reg;
    logic       scl_valid;
    logic       scl_ready;
    scl_t       scl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_data;
        end
    end

    tfs_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .scl_valid (scl_valid),
        .scl_ready (scl_ready),
        .scl       (scl)
    );

    tfs_serializer u_ser (
        .clk            (clk),
        .rst_n          (rst_n),
        .scl_valid      (scl_valid),
        .scl_ready      (scl_ready),
        .scl            (scl),
        .target_address (target_reg),
        .frm_valid      (frm_valid),
        .frm_ready      (frm_ready),
        .frm            (frm)
    );

`ifndef ASSERT_OFF
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid |-> (!frm.run_last || frm.frame_end))
        else $error("run_last without frame_end");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (scl_valid && !scl_ready))
        else $error("input stalled while scale stage can move");

    a_busy_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (scl_valid && !scl_ready) |=> frm_valid)
        else $error("serializer holds off input without producing bytes");
`endif

endmodule
